@@ hw/rtl/nfa_pkg.sv @@
package nfa_pkg;

  // Ring geometry
  localparam int MAX_SEATS = 16;
  localparam int SEAT_W    = 4;
  localparam int CNT_W     = 5;
  localparam int MEAL_W    = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] IDX_SEAT_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] IDX_MEAL_BUDGET = 1'd1;

  localparam logic [CNT_W-1:0]  SEAT_COUNT_RST  = 5'd5;
  localparam logic [MEAL_W-1:0] MEAL_BUDGET_RST = 16'd1000;
  localparam logic [MEAL_W-1:0] MEAL_MAX        = 16'hFFFF;

  // Seat states
  localparam logic [1:0] SS_THINKING = 2'd0;
  localparam logic [1:0] SS_HUNGRY   = 2'd1;
  localparam logic [1:0] SS_EATING   = 2'd2;

  // Request types
  localparam logic [1:0] REQ_TICKET = 2'd0;
  localparam logic [1:0] REQ_TAKE   = 2'd1;
  localparam logic [1:0] REQ_PUT    = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  // Result kinds
  localparam logic [2:0] RK_TICKET_GIVEN   = 3'd0;
  localparam logic [2:0] RK_TICKET_REFUSED = 3'd1;
  localparam logic [2:0] RK_GRANTED        = 3'd2;
  localparam logic [2:0] RK_NO_GRANT       = 3'd3;
  localparam logic [2:0] RK_BAD_SEAT       = 3'd4;

  // Left neighbour of s in a ring of n seats
  function automatic logic [SEAT_W-1:0] ring_left(input logic [SEAT_W-1:0] s,
                                                  input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] nm1;
    nm1 = n - 5'd1;
    if (s == '0) begin
      return nm1[SEAT_W-1:0];
    end
    return s - 4'd1;
  endfunction

  // Right neighbour of s in a ring of n seats
  function automatic logic [SEAT_W-1:0] ring_right(input logic [SEAT_W-1:0] s,
                                                   input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] sp1;
    sp1 = {1'b0, s} + 5'd1;
    if (sp1 >= n) begin
      return '0;
    end
    return sp1[SEAT_W-1:0];
  endfunction

endpackage

@@ hw/rtl/neighbour_fork_arbiter.sv @@
// Sequence: ticket and bad-seat requests finish in the accept cycle, their result
// strobing on the next cycle; ignored requests give no result. Take: PREP, SELF, LEFT,
// RIGHT, then the result. Put: PREP, then SELF, LEFT, RIGHT for each neighbour, left first;
// a second grant follows in the cycle after the first. Throughput: one ticket, bad-seat or
// ignored request per cycle; a take or put holds busy until it ends. One seat check a cycle.
// Reset (sync): all seats thinking, meal counts zero, seat_count 5, budget 1000; no stall.
module neighbour_fork_arbiter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      req_type,
  input  logic [nfa_pkg::SEAT_W-1:0]      seat,
  output logic                            done,
  output logic [2:0]                      result_kind,
  output logic [nfa_pkg::SEAT_W-1:0]      granted_seat,
  output logic [nfa_pkg::MEAL_W-1:0]      meals_taken,
  output logic                            last,
  input  logic                            cfg_we,
  input  logic [nfa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nfa_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_SELF  = 3'd2;
  localparam logic [2:0] S_LEFT  = 3'd3;
  localparam logic [2:0] S_RIGHT = 3'd4;
  localparam logic [2:0] S_EMIT2 = 3'd5;

  logic [2:0]                   state;
  logic [nfa_pkg::CNT_W-1:0]    seat_count;
  logic [nfa_pkg::MEAL_W-1:0]   meals_left;
  logic [1:0]                   seat_state [nfa_pkg::MAX_SEATS];
  logic [nfa_pkg::MEAL_W-1:0]   meal_count [nfa_pkg::MAX_SEATS];

  logic                         is_put;
  logic                         pass;
  logic                         grant_ok;
  logic                         left_granted;
  logic [nfa_pkg::SEAT_W-1:0]   cur_seat;
  logic [nfa_pkg::SEAT_W-1:0]   tgt;
  logic [nfa_pkg::SEAT_W-1:0]   hold_seat;

  logic [nfa_pkg::CNT_W-1:0]    ring_n;
  logic                         accept;
  logic                         bad_seat;
  logic [nfa_pkg::SEAT_W-1:0]   rd_addr;
  logic [1:0]                   rd_state;
  logic                         final_ok;
  logic [nfa_pkg::MEAL_W-1:0]   cnt_now;
  logic [nfa_pkg::MEAL_W-1:0]   cnt_inc;

  // Effective ring size: 0 reads as 1, saturate at the seat capacity
  always_comb begin
    if (seat_count == '0) begin
      ring_n = 5'd1;
    end else if (seat_count > nfa_pkg::CNT_W'(nfa_pkg::MAX_SEATS)) begin
      ring_n = nfa_pkg::CNT_W'(nfa_pkg::MAX_SEATS);
    end else begin
      ring_n = seat_count;
    end
  end

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign bad_seat = ({1'b0, seat} >= ring_n);

  // Shared seat-state read port, one seat per cycle
  always_comb begin
    case (state)
      S_LEFT:  rd_addr = nfa_pkg::ring_left(tgt, ring_n);
      S_RIGHT: rd_addr = nfa_pkg::ring_right(tgt, ring_n);
      default: rd_addr = tgt;
    endcase
  end
  assign rd_state = seat_state[rd_addr];
  assign final_ok = grant_ok && (rd_state != nfa_pkg::SS_EATING);

  // Ticket counter path
  assign cnt_now = meal_count[seat];
  assign cnt_inc = (cnt_now == nfa_pkg::MEAL_MAX) ? cnt_now : cnt_now + 16'd1;

  // Sequencer, seat table and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      seat_count <= nfa_pkg::SEAT_COUNT_RST;
      meals_left <= nfa_pkg::MEAL_BUDGET_RST;
      for (int i = 0; i < nfa_pkg::MAX_SEATS; i++) begin
        seat_state[i] <= nfa_pkg::SS_THINKING;
        meal_count[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && req_type != nfa_pkg::REQ_NONE) begin
            cur_seat <= seat;
            is_put   <= (req_type == nfa_pkg::REQ_PUT);
            if (bad_seat) begin
              done         <= 1'b1;
              result_kind  <= nfa_pkg::RK_BAD_SEAT;
              granted_seat <= seat;
              meals_taken  <= '0;
              last         <= 1'b1;
            end else if (req_type == nfa_pkg::REQ_TICKET) begin
              done         <= 1'b1;
              granted_seat <= seat;
              last         <= 1'b1;
              if (meals_left != '0) begin
                meals_left       <= meals_left - 16'd1;
                meal_count[seat] <= cnt_inc;
                result_kind      <= nfa_pkg::RK_TICKET_GIVEN;
                meals_taken      <= cnt_inc;
              end else begin
                result_kind <= nfa_pkg::RK_TICKET_REFUSED;
                meals_taken <= cnt_now;
              end
            end else begin
              state <= S_PREP;
            end
          end
        end
        S_PREP: begin
          pass <= 1'b0;
          if (is_put) begin
            seat_state[cur_seat] <= nfa_pkg::SS_THINKING;
            tgt                  <= nfa_pkg::ring_left(cur_seat, ring_n);
          end else begin
            seat_state[cur_seat] <= nfa_pkg::SS_HUNGRY;
            tgt                  <= cur_seat;
          end
          state <= S_SELF;
        end
        S_SELF: begin
          grant_ok <= (rd_state == nfa_pkg::SS_HUNGRY);
          state    <= S_LEFT;
        end
        S_LEFT: begin
          grant_ok <= final_ok;
          state    <= S_RIGHT;
        end
        S_RIGHT: begin
          if (final_ok) begin
            seat_state[tgt] <= nfa_pkg::SS_EATING;
          end
          if (is_put && !pass) begin
            // Left neighbour judged; go on to the right one
            left_granted <= final_ok;
            pass         <= 1'b1;
            tgt          <= nfa_pkg::ring_right(cur_seat, ring_n);
            state        <= S_SELF;
          end else begin
            done        <= 1'b1;
            meals_taken <= '0;
            last        <= 1'b1;
            state       <= S_IDLE;
            if (!is_put) begin
              result_kind  <= final_ok ? nfa_pkg::RK_GRANTED : nfa_pkg::RK_NO_GRANT;
              granted_seat <= cur_seat;
            end else if (left_granted && final_ok) begin
              result_kind  <= nfa_pkg::RK_GRANTED;
              granted_seat <= nfa_pkg::ring_left(cur_seat, ring_n);
              last         <= 1'b0;
              hold_seat    <= tgt;
              state        <= S_EMIT2;
            end else if (left_granted) begin
              result_kind  <= nfa_pkg::RK_GRANTED;
              granted_seat <= nfa_pkg::ring_left(cur_seat, ring_n);
            end else if (final_ok) begin
              result_kind  <= nfa_pkg::RK_GRANTED;
              granted_seat <= tgt;
            end else begin
              result_kind  <= nfa_pkg::RK_NO_GRANT;
              granted_seat <= cur_seat;
            end
          end
        end
        S_EMIT2: begin
          done         <= 1'b1;
          result_kind  <= nfa_pkg::RK_GRANTED;
          granted_seat <= hold_seat;
          meals_taken  <= '0;
          last         <= 1'b1;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // Configuration writes, taken while idle: the user must keep to this; the block does not enforce it
      if (cfg_we) begin
        case (cfg_index)
          nfa_pkg::IDX_SEAT_COUNT:  seat_count <= cfg_data[nfa_pkg::CNT_W-1:0];
          nfa_pkg::IDX_MEAL_BUDGET: meals_left <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Ignored and bad-seat requests never start the sequencer
  a_no_busy_on_ignored: assert property (@(posedge clk) disable iff (rst)
    (accept && (req_type == nfa_pkg::REQ_NONE || bad_seat)) |=> !busy)
    else $error("sequencer started on an ignored or bad-seat request");

  // Second grant follows a first result that is not marked last
  a_first_of_two: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT2) |-> (done && !last && result_kind == nfa_pkg::RK_GRANTED))
    else $error("second grant without a non-final first result");

  // Meal count only reported on ticket results
  a_meals_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result_kind != nfa_pkg::RK_TICKET_GIVEN &&
     result_kind != nfa_pkg::RK_TICKET_REFUSED) |-> (meals_taken == '0))
    else $error("meal count on a non-ticket result");

  // The second grant strobes done, marked last, and the sequencer returns to idle
  a_emit2_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT2) |=> (done && last && state == S_IDLE))
    else $error("second grant not delivered");

endmodule
